// File: sv/rsla_pkg.sv
// Shared types and constants for the reassembly slot allocator.
// Used by the front end, request queue, back end, top level and checker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rsla_pkg;

    localparam int SLOTS    = 4;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int COUNT_W  = 16;
    localparam int LENGTH_W = 32;
    localparam int SLOT_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int OUTC_W   = 2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 8;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic CMD_ROUTE   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        RK_ROUTE,
        RK_RELEASE,
        RK_RELEASE_NONE
    } req_kind_t;

    typedef enum logic [OUTC_W-1:0] {
        OC_MATCH    = 2'd0,
        OC_FREE     = 2'd1,
        OC_EVICT    = 2'd2,
        OC_RELEASED = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EVICT
    } back_state_t;

    typedef struct packed {
        req_kind_t             kind;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_W-1:0]    count;
        logic [LENGTH_W-1:0]   length;
        logic [SLOT_W-1:0]     rel_slot;
    } req_t;

    typedef struct packed {
        logic pop;
        logic release_wr;
        logic fast_wr;
        logic scan_start;
        logic evict_wr;
        logic out_load;
    } back_ctl_t;

endpackage

`default_nettype wire

// File: sv/reassembly_slot_lru_allocator_core.sv
// Top level of the reassembly slot allocator: front end, request queue, back end.
// Depends on rsla_pkg, rsla_front, rsla_queue and rsla_back.
//
//   Channel   Direction  tdata (lowest bit up)                          tuser
//   s_        in         resource_key, fragment_count, total_length,     command
//                        release_slot, zero padding (120 bits)
//   m_        out        slot, zero padding (8 bits)                     outcome
//
// A release, and a route that matches an active slot or finds a free one,
// is handled in the back end when it is popped. A route that must evict
// runs an age scan through one slot per cycle on a single signed comparator;
// the chosen slot is written once the result register is free.
// Reset is synchronous and active low; it clears the active bits, the stamps,
// the use counter, the queue and the result valid bit, with no clearing pass.
// A two-entry queue parts the two sides, so input transactions are taken
// while a result waits on m_tready; the back end stalls only on a full result
// register.
`timescale 1ns / 1ps
`default_nettype none

module reassembly_slot_lru_allocator_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // resource_key[63:0], fragment_count[79:64], total_length[111:80],
    // release_slot[115:112], zero padding above
    input  wire logic [rsla_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  wire logic [0:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // slot[3:0], zero padding above
    output logic [rsla_pkg::M_TDATA_W-1:0]      m_tdata,
    // outcome[1:0]
    output logic [rsla_pkg::OUTC_W-1:0]         m_tuser
);

    // Front end to queue
    logic            push_valid;
    logic            push_ready;
    rsla_pkg::req_t  push_req;

    // Queue to back end
    logic            q_valid;
    logic            q_pop;
    rsla_pkg::req_t  q_req;

    // The front end decodes the command and checks the release index,
    // so the back end sees a ready-made request kind.
    rsla_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    // Requests wait here while the back end is busy scanning or stalled.
    rsla_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_req    (q_req)
    );

    // The back end owns the slot table and the result register.
    rsla_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: sv/rsla_front.sv
// Front end: unpacks an input transaction and classifies it for the back end.
// Depends on rsla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsla_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rsla_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]                     s_tuser,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output rsla_pkg::req_t                      push_req
);

    logic [rsla_pkg::SLOT_W-1:0] rel_slot;
    logic                        rel_in_range;

    assign rel_slot     = s_tdata[115:112];
    assign rel_in_range = ({1'b0, rel_slot} < (rsla_pkg::SLOT_W + 1)'(rsla_pkg::SLOTS));

    always_comb begin
        push_req.key      = s_tdata[rsla_pkg::KEY_BITS-1:0];
        push_req.count    = s_tdata[79:64];
        push_req.length   = s_tdata[111:80];
        push_req.rel_slot = rel_slot;
        if (s_tuser[0] == rsla_pkg::CMD_ROUTE) begin
            push_req.kind = rsla_pkg::RK_ROUTE;
        end else if (rel_in_range) begin
            push_req.kind = rsla_pkg::RK_RELEASE;
        end else begin
            // Release of a slot that does not exist only echoes the index.
            push_req.kind = rsla_pkg::RK_RELEASE_NONE;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

// File: sv/rsla_queue.sv
// Short request queue that decouples the front end from the back end.
// Depends on rsla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsla_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire rsla_pkg::req_t push_req,
    output logic                pop_valid,
    input  wire logic           pop,
    output rsla_pkg::req_t      pop_req
);

    rsla_pkg::req_t                 entry_reg [rsla_pkg::QDEPTH];
    logic [rsla_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rsla_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rsla_pkg::QCNT_W-1:0]    fill_reg, fill_next;
    logic                           do_push, do_pop;

    assign push_ready = (fill_reg != rsla_pkg::QCNT_W'(rsla_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == rsla_pkg::QPTR_W'(rsla_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == rsla_pkg::QPTR_W'(rsla_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// File: sv/rsla_back.sv
// Back end: slot table, match and free search, serial age scan for eviction,
// and the result register. Depends on rsla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsla_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire rsla_pkg::req_t                 q_req,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rsla_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [rsla_pkg::OUTC_W-1:0]         m_tuser
);

    localparam int IW = rsla_pkg::IDX_W;
    localparam int SN = rsla_pkg::SLOTS;

    // Slot table
    logic                            active_reg [SN];
    logic [rsla_pkg::KEY_BITS-1:0]   key_reg    [SN];
    logic [rsla_pkg::COUNT_W-1:0]    count_reg  [SN];
    logic [rsla_pkg::LENGTH_W-1:0]   length_reg [SN];
    logic [rsla_pkg::STAMP_W-1:0]    stamp_reg  [SN];
    logic [rsla_pkg::STAMP_W-1:0]    counter_reg;
    logic [rsla_pkg::STAMP_W-1:0]    counter_inc;

    // Held route request while the age scan runs
    logic [rsla_pkg::KEY_BITS-1:0]   hold_key_reg;
    logic [rsla_pkg::COUNT_W-1:0]    hold_count_reg;
    logic [rsla_pkg::LENGTH_W-1:0]   hold_length_reg;
    logic [IW-1:0]                   scan_idx_reg;
    logic [IW-1:0]                   best_idx_reg;
    logic [rsla_pkg::STAMP_W-1:0]    best_age_reg;

    rsla_pkg::back_state_t           state_reg, state_next;
    rsla_pkg::back_ctl_t             ctl;

    logic                            out_valid_reg;
    logic [rsla_pkg::SLOT_W-1:0]     out_slot_reg;
    rsla_pkg::outcome_t              out_outcome_reg;

    logic                            out_free;
    logic                            hit_any, free_any;
    logic [IW-1:0]                   hit_idx, free_idx, fast_idx;
    rsla_pkg::outcome_t              fast_outcome;
    logic [rsla_pkg::STAMP_W-1:0]    age_first, age_cand;
    logic                            is_route, is_release;

    assign out_free    = !out_valid_reg || m_tready;
    assign counter_inc = counter_reg + 1'b1;
    assign is_route    = (q_req.kind == rsla_pkg::RK_ROUTE);
    assign is_release  = (q_req.kind == rsla_pkg::RK_RELEASE);

    // Parallel match and free search; the lowest index wins.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SN - 1; i >= 0; i--) begin
            if (active_reg[i] && key_reg[i] == q_req.key &&
                count_reg[i] == q_req.count && length_reg[i] == q_req.length) begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!active_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
        fast_idx     = hit_any ? hit_idx : free_idx;
        fast_outcome = hit_any ? rsla_pkg::OC_MATCH : rsla_pkg::OC_FREE;
    end

    assign age_first = counter_reg - stamp_reg[0];
    assign age_cand  = counter_reg - stamp_reg[scan_idx_reg];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsla_pkg::BK_IDLE: begin
                if (q_valid && out_free && is_route && !hit_any && !free_any) begin
                    state_next = rsla_pkg::BK_SCAN;
                end
            end
            rsla_pkg::BK_SCAN: begin
                if (scan_idx_reg == IW'(SN - 1)) begin
                    state_next = rsla_pkg::BK_EVICT;
                end
            end
            rsla_pkg::BK_EVICT: begin
                if (out_free) begin
                    state_next = rsla_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = rsla_pkg::BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        ctl.pop        = (state_reg == rsla_pkg::BK_IDLE) && q_valid && out_free;
        ctl.release_wr = ctl.pop && is_release;
        ctl.fast_wr    = ctl.pop && is_route && (hit_any || free_any);
        ctl.scan_start = ctl.pop && is_route && !hit_any && !free_any;
        ctl.evict_wr   = (state_reg == rsla_pkg::BK_EVICT) && out_free;
        ctl.out_load   = (ctl.pop && !ctl.scan_start) || ctl.evict_wr;
    end

    assign q_pop = ctl.pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsla_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
            for (int i = 0; i < SN; i++) begin
                active_reg[i] <= 1'b0;
                stamp_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (ctl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.release_wr) begin
                active_reg[q_req.rel_slot[IW-1:0]] <= 1'b0;
            end
            if (ctl.fast_wr) begin
                active_reg[fast_idx] <= 1'b1;
                stamp_reg[fast_idx]  <= counter_inc;
                counter_reg          <= counter_inc;
            end
            if (ctl.evict_wr) begin
                active_reg[best_idx_reg] <= 1'b1;
                stamp_reg[best_idx_reg]  <= counter_inc;
                counter_reg              <= counter_inc;
            end
        end
    end

    // Payload: slot contents, held request, scan registers, result fields
    always_ff @(posedge aclk) begin
        if (ctl.release_wr) begin
            key_reg[q_req.rel_slot[IW-1:0]]    <= '0;
            count_reg[q_req.rel_slot[IW-1:0]]  <= '0;
            length_reg[q_req.rel_slot[IW-1:0]] <= '0;
        end
        if (ctl.fast_wr && !hit_any) begin
            key_reg[fast_idx]    <= q_req.key;
            count_reg[fast_idx]  <= q_req.count;
            length_reg[fast_idx] <= q_req.length;
        end
        if (ctl.evict_wr) begin
            key_reg[best_idx_reg]    <= hold_key_reg;
            count_reg[best_idx_reg]  <= hold_count_reg;
            length_reg[best_idx_reg] <= hold_length_reg;
        end
        if (ctl.scan_start) begin
            hold_key_reg    <= q_req.key;
            hold_count_reg  <= q_req.count;
            hold_length_reg <= q_req.length;
            best_idx_reg    <= '0;
            best_age_reg    <= age_first;
            scan_idx_reg    <= IW'(1);
        end else if (state_reg == rsla_pkg::BK_SCAN) begin
            // Signed age; a strictly larger one replaces, so ties keep the lower slot.
            if ($signed(age_cand) > $signed(best_age_reg)) begin
                best_idx_reg <= scan_idx_reg;
                best_age_reg <= age_cand;
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (ctl.evict_wr) begin
            out_slot_reg    <= rsla_pkg::SLOT_W'(best_idx_reg);
            out_outcome_reg <= rsla_pkg::OC_EVICT;
        end else if (ctl.fast_wr) begin
            out_slot_reg    <= rsla_pkg::SLOT_W'(fast_idx);
            out_outcome_reg <= fast_outcome;
        end else if (ctl.out_load) begin
            out_slot_reg    <= q_req.rel_slot;
            out_outcome_reg <= rsla_pkg::OC_RELEASED;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rsla_pkg::M_TDATA_W'(out_slot_reg);
    assign m_tuser  = out_outcome_reg;

endmodule

`default_nettype wire

// File: sv/rsla_checker.sv
// Port-level checker for the reassembly slot allocator, bound to the top level.
// Depends on rsla_pkg and reassembly_slot_lru_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module rsla_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [rsla_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [rsla_pkg::OUTC_W-1:0]    m_tuser
);

    // A result held back by the sink keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A route result always names a slot that exists.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rsla_pkg::OC_RELEASED |->
        ({1'b0, m_tdata[3:0]} < 5'(rsla_pkg::SLOTS)))
        else $error("route result names a slot beyond the pool");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid just after reset");

endmodule

bind reassembly_slot_lru_allocator_core rsla_checker u_rsla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
